// ===== src/script_tokenizer_unit_defines.svh =====
// Assertion macros shared by the script tokenizer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SCRIPT_TOKENIZER_UNIT_DEFINES_SVH
`define SCRIPT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock while out of reset.
`define STU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock while out of reset.
`define STU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stu_pkg.sv =====
// Types and character constants for the script tokenizer.
// No dependencies; imported by script_tokenizer_unit.
`default_nettype none

package stu_pkg;

    typedef enum logic [5:0] {
        ST_SPACE   = 6'b000001,
        ST_BREAK   = 6'b000010,
        ST_COMMENT = 6'b000100,
        ST_NUMBER  = 6'b001000,
        ST_SYMBOL  = 6'b010000,
        ST_STRING  = 6'b100000
    } lex_state_t;

    typedef enum logic [2:0] {
        KIND_BREAK  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_SYMBOL = 3'd2,
        KIND_STRING = 3'd3,
        KIND_DEF    = 3'd4
    } token_kind_t;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

endpackage

`default_nettype wire

// ===== src/script_tokenizer_unit.sv =====
// Script tokenizer: one script byte per request in, token descriptors out.
// Depends on stu_pkg and script_tokenizer_unit_defines.svh.
//
//   Channel  Ports                                      Carries
//   s_       s_valid s_ready s_ch s_restart             one script byte per request
//   m_       m_valid m_ready m_token_kind/start/length  one token descriptor per request
//
// Each byte is lexed in the cycle it is accepted; a token comes out of the
// output register in the next cycle, so one byte per clock is sustained while m_ready is high.
// The only stored element between the channels is that output register: a
// new byte is taken whenever it is empty or being drained in the same cycle.
// Synchronous active-low reset clears the lexer state, counters and m_valid.
// After MAX_INPUT_BYTES bytes, further bytes are taken and dropped until a
// request with s_restart set.
`default_nettype none

`include "script_tokenizer_unit_defines.svh"

module script_tokenizer_unit
    import stu_pkg::*;
#(
    parameter int MAX_INPUT_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_token_kind,
    output logic [15:0]      m_token_start,
    output logic [15:0]      m_token_length
);

    localparam int CntW = $clog2(MAX_INPUT_BYTES + 1);
    localparam logic [CntW-1:0] MaxCount = CntW'(MAX_INPUT_BYTES);

    lex_state_t      lex_state_reg, lex_state_next;
    logic            pending_break_reg, pending_break_next;
    logic [15:0]     start_pos_reg, start_pos_next;
    logic [15:0]     byte_pos_reg, byte_pos_next;
    logic [CntW-1:0] bytes_seen_reg, bytes_seen_next;

    logic            m_valid_reg, m_valid_next;
    token_kind_t     kind_reg, kind_next;
    logic [15:0]     tok_start_reg, tok_start_next;
    logic [15:0]     tok_len_reg, tok_len_next;

    lex_state_t      base_state, sp_state;
    logic            base_pending;
    logic [15:0]     base_start, sp_start, pos, run_len;
    logic [CntW-1:0] base_seen;
    logic            limited, accept, emit;
    logic [7:0]      c;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // A restart clears everything before the byte is looked at.
        base_state   = s_restart ? ST_SPACE : lex_state_reg;
        base_pending = s_restart ? 1'b0 : pending_break_reg;
        base_start   = s_restart ? 16'd0 : start_pos_reg;
        pos          = s_restart ? 16'd0 : byte_pos_reg;
        base_seen    = s_restart ? '0 : bytes_seen_reg;
        limited      = base_seen >= MaxCount;

        c = s_ch;
        if (c inside {CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN, CH_TAB}) begin
            c = CH_SPACE;
        end

        run_len = pos - base_start;

        // Space-state behavior, also used when a break region ends.
        sp_start = base_start;
        if (c == CH_SPACE) begin
            sp_state = ST_SPACE;
        end else if (c == CH_NEWLINE) begin
            sp_state = ST_BREAK;
        end else if (c == CH_HASH) begin
            sp_state = ST_COMMENT;
        end else if (c == CH_QUOTE) begin
            sp_state = ST_STRING;
            sp_start = pos + 16'd1;
        end else if (c inside {[CH_ZERO:CH_NINE], CH_MINUS}) begin
            sp_state = ST_NUMBER;
            sp_start = pos;
        end else begin
            sp_state = ST_SYMBOL;
            sp_start = pos;
        end

        lex_state_next     = base_state;
        pending_break_next = base_pending;
        start_pos_next     = base_start;
        byte_pos_next      = pos;
        bytes_seen_next    = base_seen;
        emit               = 1'b0;
        kind_next          = kind_reg;
        tok_start_next     = tok_start_reg;
        tok_len_next       = tok_len_reg;

        if (!limited) begin
            byte_pos_next   = pos + 16'd1;
            bytes_seen_next = base_seen + CntW'(1);
            case (base_state)
                ST_BREAK: begin
                    if (c == CH_SPACE) begin
                        lex_state_next = ST_BREAK;
                    end else if (c == CH_HASH) begin
                        pending_break_next = 1'b1;
                        lex_state_next     = ST_COMMENT;
                    end else if (c == CH_NEWLINE) begin
                        pending_break_next = 1'b1;
                    end else begin
                        if (base_pending) begin
                            emit               = 1'b1;
                            kind_next          = KIND_BREAK;
                            tok_start_next     = 16'd0;
                            tok_len_next       = 16'd0;
                            pending_break_next = 1'b0;
                        end
                        lex_state_next = sp_state;
                        start_pos_next = sp_start;
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        lex_state_next = ST_BREAK;
                    end
                end
                ST_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit           = 1'b1;
                        kind_next      = KIND_STRING;
                        tok_start_next = base_start;
                        tok_len_next   = run_len;
                        lex_state_next = ST_SPACE;
                    end
                end
                ST_NUMBER, ST_SYMBOL: begin
                    if (c inside {CH_COLON, CH_HASH, CH_SPACE, CH_NEWLINE}) begin
                        // A run whose length wrapped to zero is dropped.
                        emit = run_len != 16'd0;
                        if (c == CH_COLON) begin
                            kind_next = KIND_DEF;
                        end else if (base_state == ST_NUMBER) begin
                            kind_next = KIND_NUMBER;
                        end else begin
                            kind_next = KIND_SYMBOL;
                        end
                        tok_start_next = base_start;
                        tok_len_next   = run_len;
                        if (c == CH_HASH) begin
                            lex_state_next = ST_COMMENT;
                        end else if (c == CH_NEWLINE) begin
                            lex_state_next = ST_BREAK;
                        end else begin
                            lex_state_next = ST_SPACE;
                        end
                    end
                end
                default: begin
                    lex_state_next = sp_state;
                    start_pos_next = sp_start;
                end
            endcase
        end

        if (accept) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lex_state_reg     <= ST_SPACE;
            pending_break_reg <= 1'b0;
            start_pos_reg     <= 16'd0;
            byte_pos_reg      <= 16'd0;
            bytes_seen_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                lex_state_reg     <= lex_state_next;
                pending_break_reg <= pending_break_next;
                start_pos_reg     <= start_pos_next;
                byte_pos_reg      <= byte_pos_next;
                bytes_seen_reg    <= bytes_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg      <= kind_next;
            tok_start_reg <= tok_start_next;
            tok_len_reg   <= tok_len_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_token_kind   = kind_reg;
    assign m_token_start  = tok_start_reg;
    assign m_token_length = tok_len_reg;

    `STU_ASSERT_NOW(a_seen_bound, aclk, aresetn, 1'b1, bytes_seen_reg <= MaxCount, "byte count passed the input limit")
    `STU_ASSERT_NOW(a_pending_state, aclk, aresetn, pending_break_reg, lex_state_reg == ST_BREAK || lex_state_reg == ST_COMMENT, "break owed outside a break region")
    `STU_ASSERT_NOW(a_break_zero, aclk, aresetn, m_valid && m_token_kind == KIND_BREAK, m_token_start == 16'd0 && m_token_length == 16'd0, "break token with nonzero fields")
    `STU_ASSERT_NEXT(a_pos_step, aclk, aresetn, accept && !s_restart && bytes_seen_reg < MaxCount, byte_pos_reg == 16'($past(byte_pos_reg) + 16'd1), "byte position did not advance")

endmodule

`default_nettype wire
